[rtl/core/bar_pair_x_gap_statistics_unit_macros.svh]
// Assertion macros for the checker file of this block.
`ifndef BAR_PAIR_X_GAP_STATISTICS_UNIT_MACROS_SVH
`define BAR_PAIR_X_GAP_STATISTICS_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPXG_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BPXG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/bpxg_pkg.sv]
package bpxg_pkg;

	// Store geometry.
	localparam int MAX_BARS = 256;
	localparam int IDX_W    = $clog2(MAX_BARS);
	localparam int CNT_W    = $clog2(MAX_BARS + 1);
	localparam int REC_W    = 8 + 4 * 32;

	// Gap arithmetic widths.
	localparam int GAP_W    = 35;
	localparam int SAT_W    = GAP_W + 1;
	localparam int GCNT_W   = $clog2(2 * MAX_BARS * MAX_BARS + 1);
	localparam int SUM_W    = GAP_W + GCNT_W;
	localparam int CNTO_W   = 18;
	localparam int CMP_W    = (GCNT_W > CNTO_W) ? GCNT_W : CNTO_W;
	localparam int COUNT_MAX = 262143;

	// Shared divider.
	localparam int DIV_N    = 64;
	localparam int DVS_W    = 32;

	// Request codes.
	localparam logic [1:0] ACT_CLEAR   = 2'd0;
	localparam logic [1:0] ACT_LOAD    = 2'd1;
	localparam logic [1:0] ACT_COMPUTE = 2'd2;

	// Register indexes.
	localparam logic [1:0] REG_FIRST  = 2'd0;
	localparam logic [1:0] REG_SECOND = 2'd1;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// Clamp a signed value to the 32-bit range.
	function automatic logic [31:0] sat32(input logic signed [SAT_W-1:0] v);
		logic [31:0] r;
		if (&v[SAT_W-1:31] || ~|v[SAT_W-1:31]) begin
			r = v[31:0];
		end else if (v[SAT_W-1]) begin
			r = 32'h8000_0000;
		end else begin
			r = 32'h7fff_ffff;
		end
		return r;
	endfunction

endpackage

[rtl/core/bar_pair_x_gap_statistics_unit.sv]
// Channel  Direction  Handshake               Payload
// in       request    in_valid / in_ready     action, bar_type, start_x, start_y, end_x, end_y
// out      result     out_valid / out_ready   gap_count, min_gap, max_gap, mean_gap
// cfg      write      cfg_we                  cfg_index, cfg_data
//
// Clear and load requests are taken while idle and may follow back to back.
// A compute request pairs each end of every bar of the point type with every bar of the
// other type, in both passes, and runs the 64-step shared divider once per point that
// meets a bar, then once more for the mean division when any gap was found.
// Reset clears the bar count, the registers and the result register; the store needs none.
// A waiting result does not block loads; a compute finishing while one waits holds until taken.
module bar_pair_x_gap_statistics_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  action,
	input  logic [7:0]                  bar_type,
	input  logic signed [31:0]          start_x,
	input  logic signed [31:0]          start_y,
	input  logic signed [31:0]          end_x,
	input  logic signed [31:0]          end_y,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [17:0]                 gap_count,
	output logic signed [31:0]          min_gap,
	output logic signed [31:0]          max_gap,
	output logic signed [31:0]          mean_gap,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [7:0]                  cfg_data
);

	localparam int CNT_W  = bpxg_pkg::CNT_W;
	localparam int GAP_W  = bpxg_pkg::GAP_W;
	localparam int SUM_W  = bpxg_pkg::SUM_W;
	localparam int GCNT_W = bpxg_pkg::GCNT_W;
	localparam int SAT_W  = bpxg_pkg::SAT_W;
	localparam int CMP_W  = bpxg_pkg::CMP_W;

	typedef enum logic [3:0] {
		S_IDLE, S_I_RD, S_I_CHK, S_J_RD, S_J_CHK, S_TEST, S_MUL,
		S_DSTART, S_DWAIT, S_GAP, S_MEAN, S_MWAIT, S_OUT
	} state_t;

	state_t                     state_q;
	logic [7:0]                 first_q, second_q;
	logic [CNT_W-1:0]           nbar_q, i_q, j_q;
	logic                       pass_q, e_q;
	logic [31:0]                ptx0_q, pty0_q, ptx1_q, pty1_q;
	logic signed [32:0]         px_q, py_q, ax_q, ay_q, bx_q, by_q;
	logic [31:0]                mdx_q, mt_q, md_q;
	logic                       neg_q, hit;
	logic signed [GAP_W-1:0]    base_q;
	logic [63:0]                prod_q;
	logic [GCNT_W-1:0]          gcnt_q;
	logic signed [GAP_W-1:0]    min_q, max_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic                       out_valid_q;

	logic [bpxg_pkg::REC_W-1:0] wrec, pt_rd, bar_rd;
	logic                       store_we;
	logic [7:0]                 pt_type, br_type;
	logic signed [33:0]         dx, tt, dd;
	logic [33:0]                adx, att, add;
	logic signed [32:0]         qs;
	logic signed [GAP_W-1:0]    gap;
	logic [SUM_W-1:0]           sum_mag;
	logic                       div_start;
	logic [bpxg_pkg::DIV_N-1:0] div_dvd, div_quo;
	logic [bpxg_pkg::DVS_W-1:0] div_dvs;
	bpxg_pkg::div_stat_t        div_st;
	logic [CMP_W-1:0]           cnt_ext;
	logic [GAP_W-1:0]           mean_mag;
	logic signed [SAT_W-1:0]    mean_s;

	// Sign-extend a coordinate and negate it on the reverse pass.
	function automatic logic signed [32:0] coord(input logic [31:0] v, input logic n);
		logic signed [32:0] x;
		x = {v[31], v};
		return n ? -x : x;
	endfunction

	// Two copies of the bar store, one walked by point bar, one by projected bar.
	assign wrec     = {bar_type, start_x, start_y, end_x, end_y};
	assign store_we = (state_q == S_IDLE) && in_valid && (action == bpxg_pkg::ACT_LOAD)
		&& (nbar_q < CNT_W'(bpxg_pkg::MAX_BARS));

	bpxg_ram #(.WIDTH(bpxg_pkg::REC_W), .DEPTH(bpxg_pkg::MAX_BARS)) u_pt_ram (
		.clk   (clk),
		.we    (store_we),
		.waddr (nbar_q[bpxg_pkg::IDX_W-1:0]),
		.wdata (wrec),
		.raddr (i_q[bpxg_pkg::IDX_W-1:0]),
		.rdata (pt_rd)
	);

	bpxg_ram #(.WIDTH(bpxg_pkg::REC_W), .DEPTH(bpxg_pkg::MAX_BARS)) u_bar_ram (
		.clk   (clk),
		.we    (store_we),
		.waddr (nbar_q[bpxg_pkg::IDX_W-1:0]),
		.wdata (wrec),
		.raddr (j_q[bpxg_pkg::IDX_W-1:0]),
		.rdata (bar_rd)
	);

	// Pass roles and the span test.
	always_comb begin
		pt_type = pass_q ? second_q : first_q;
		br_type = pass_q ? first_q : second_q;
		dx  = 34'(bx_q) - 34'(ax_q);
		tt  = 34'(py_q) - 34'(ay_q);
		dd  = 34'(by_q) - 34'(ay_q);
		adx = dx[33] ? 34'(-dx) : 34'(dx);
		att = tt[33] ? 34'(-tt) : 34'(tt);
		add = dd[33] ? 34'(-dd) : 34'(dd);
		hit = ((py_q >= ay_q) && (py_q < by_q)) || ((py_q < ay_q) && (py_q >= by_q));
		qs  = neg_q ? -$signed({1'b0, div_quo[31:0]}) : $signed({1'b0, div_quo[31:0]});
		gap = base_q + GAP_W'(qs);
		sum_mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	end

	// Shared divider: projection quotient, then the mean.
	assign div_start = (state_q == S_DSTART) || ((state_q == S_MEAN) && (gcnt_q != '0));
	assign div_dvd   = (state_q == S_MEAN) ? bpxg_pkg::DIV_N'(sum_mag) : prod_q;
	assign div_dvs   = (state_q == S_MEAN) ? bpxg_pkg::DVS_W'(gcnt_q) : md_q;

	bpxg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.quotient (div_quo),
		.stat     (div_st)
	);

	// Result formatting.
	always_comb begin
		cnt_ext  = CMP_W'(gcnt_q);
		mean_mag = div_quo[GAP_W-1:0];
		mean_s   = sum_q[SUM_W-1] ? -$signed({1'b0, mean_mag}) : $signed({1'b0, mean_mag});
	end

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= '0;
			second_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				bpxg_pkg::REG_FIRST:  first_q  <= cfg_data;
				bpxg_pkg::REG_SECOND: second_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer with accumulators and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			nbar_q      <= '0;
			i_q         <= '0;
			j_q         <= '0;
			pass_q      <= 1'b0;
			e_q         <= 1'b0;
			gcnt_q      <= '0;
			out_valid_q <= 1'b0;
			gap_count   <= '0;
			min_gap     <= '0;
			max_gap     <= '0;
			mean_gap    <= '0;
		end else begin
			if (out_valid_q && out_ready && (state_q != S_OUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						case (action)
							bpxg_pkg::ACT_CLEAR: nbar_q <= '0;
							bpxg_pkg::ACT_LOAD: begin
								if (store_we) begin
									nbar_q <= nbar_q + CNT_W'(1);
								end
							end
							bpxg_pkg::ACT_COMPUTE: begin
								gcnt_q  <= '0;
								sum_q   <= '0;
								min_q   <= '0;
								max_q   <= '0;
								pass_q  <= 1'b0;
								i_q     <= '0;
								state_q <= S_I_RD;
							end
							default: ;
						endcase
					end
				end
				S_I_RD: begin
					if (i_q == nbar_q) begin
						if (!pass_q) begin
							pass_q <= 1'b1;
							i_q    <= '0;
						end else begin
							state_q <= S_MEAN;
						end
					end else begin
						state_q <= S_I_CHK;
					end
				end
				S_I_CHK: begin
					if (pt_rd[135:128] == pt_type) begin
						ptx0_q  <= pt_rd[127:96];
						pty0_q  <= pt_rd[95:64];
						ptx1_q  <= pt_rd[63:32];
						pty1_q  <= pt_rd[31:0];
						e_q     <= 1'b0;
						j_q     <= '0;
						state_q <= S_J_RD;
					end else begin
						i_q     <= i_q + CNT_W'(1);
						state_q <= S_I_RD;
					end
				end
				S_J_RD: begin
					if (j_q == nbar_q) begin
						if (!e_q) begin
							e_q <= 1'b1;
							j_q <= '0;
						end else begin
							i_q     <= i_q + CNT_W'(1);
							state_q <= S_I_RD;
						end
					end else begin
						state_q <= S_J_CHK;
					end
				end
				S_J_CHK: begin
					if (bar_rd[135:128] == br_type) begin
						px_q    <= coord(e_q ? ptx1_q : ptx0_q, pass_q);
						py_q    <= coord(e_q ? pty1_q : pty0_q, pass_q);
						ax_q    <= coord(bar_rd[127:96], pass_q);
						ay_q    <= coord(bar_rd[95:64], pass_q);
						bx_q    <= coord(bar_rd[63:32], pass_q);
						by_q    <= coord(bar_rd[31:0], pass_q);
						state_q <= S_TEST;
					end else begin
						j_q     <= j_q + CNT_W'(1);
						state_q <= S_J_RD;
					end
				end
				S_TEST: begin
					mdx_q  <= adx[31:0];
					mt_q   <= att[31:0];
					md_q   <= add[31:0];
					neg_q  <= dx[33];
					base_q <= GAP_W'(ax_q) - GAP_W'(px_q);
					if (hit) begin
						state_q <= S_MUL;
					end else begin
						j_q     <= j_q + CNT_W'(1);
						state_q <= S_J_RD;
					end
				end
				S_MUL: begin
					prod_q  <= mdx_q * mt_q;
					state_q <= S_DSTART;
				end
				S_DSTART: state_q <= S_DWAIT;
				S_DWAIT: begin
					if (div_st.done) begin
						state_q <= S_GAP;
					end
				end
				S_GAP: begin
					if (gcnt_q == '0 || gap < min_q) begin
						min_q <= gap;
					end
					if (gcnt_q == '0 || gap > max_q) begin
						max_q <= gap;
					end
					sum_q   <= sum_q + SUM_W'(gap);
					gcnt_q  <= gcnt_q + GCNT_W'(1);
					j_q     <= j_q + CNT_W'(1);
					state_q <= S_J_RD;
				end
				S_MEAN: state_q <= (gcnt_q == '0) ? S_OUT : S_MWAIT;
				S_MWAIT: begin
					if (div_st.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						if (gcnt_q == '0) begin
							gap_count <= '0;
							min_gap   <= '0;
							max_gap   <= '0;
							mean_gap  <= '0;
						end else begin
							gap_count <= (cnt_ext > CMP_W'(bpxg_pkg::COUNT_MAX)) ? '1
								: cnt_ext[17:0];
							min_gap   <= bpxg_pkg::sat32(SAT_W'(min_q));
							max_gap   <= bpxg_pkg::sat32(SAT_W'(max_q));
							mean_gap  <= bpxg_pkg::sat32(mean_s);
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[rtl/core/bpxg_ram.sv]
module bpxg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/bpxg_div.sv]
module bpxg_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [bpxg_pkg::DIV_N-1:0]  dividend,
	input  logic [bpxg_pkg::DVS_W-1:0]  divisor,
	output logic [bpxg_pkg::DIV_N-1:0]  quotient,
	output bpxg_pkg::div_stat_t         stat
);

	localparam int STEP_W = $clog2(bpxg_pkg::DIV_N + 1);

	logic [STEP_W-1:0]              cnt_q;
	logic [bpxg_pkg::DVS_W-1:0]     rem_q;
	logic [bpxg_pkg::DVS_W-1:0]     dvs_q;
	logic [bpxg_pkg::DIV_N-1:0]     quo_q;
	logic                           done_q;
	logic [bpxg_pkg::DVS_W:0]       trial;
	logic [bpxg_pkg::DVS_W:0]       diff;
	logic                           ge;

	// One restoring step: bring down the next dividend bit and try a subtract.
	always_comb begin
		trial = {rem_q, quo_q[bpxg_pkg::DIV_N-1]};
		diff  = trial - {1'b0, dvs_q};
		ge    = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == STEP_W'(1)) && !start;
			if (start) begin
				cnt_q <= STEP_W'(bpxg_pkg::DIV_N);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - STEP_W'(1);
			end
		end
	end

	// Datapath registers need no reset.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[bpxg_pkg::DVS_W-1:0] : trial[bpxg_pkg::DVS_W-1:0];
			quo_q <= {quo_q[bpxg_pkg::DIV_N-2:0], ge};
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = cnt_q != '0;
	assign stat.done = done_q;

endmodule

[rtl/core/bpxg_chk.sv]
`include "bar_pair_x_gap_statistics_unit_macros.svh"

module bpxg_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic [1:0]         action,
	input logic               out_valid,
	input logic               out_ready,
	input logic [17:0]        gap_count,
	input logic signed [31:0] min_gap,
	input logic signed [31:0] max_gap,
	input logic signed [31:0] mean_gap
);

	// A result that is not taken stays on offer.
	`BPXG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

	// An accepted compute request blocks further requests.
	`BPXG_ASSERT_NEXT(a_compute_busy, in_valid && in_ready && action == bpxg_pkg::ACT_COMPUTE, !in_ready, "request taken during compute")

	// With no gap found every statistic reads zero.
	`BPXG_ASSERT_SAME(a_empty_zero, out_valid && gap_count == '0, min_gap == '0 && max_gap == '0 && mean_gap == '0, "empty result not zero")

	// The mean lies between the extremes.
	`BPXG_ASSERT_SAME(a_mean_range, out_valid, mean_gap >= min_gap && mean_gap <= max_gap, "mean outside min and max")

endmodule

bind bar_pair_x_gap_statistics_unit bpxg_chk u_bpxg_chk (.*);
